FILE: hdl/lzpwc_pkg.sv
// Shared types and constants for the LZP word compressor.
package lzpwc_pkg;

   localparam int WORD_W     = 16;
   localparam int LIT_DEPTH  = 16;
   localparam int LIT_IDX_W  = 4;
   localparam int CNT_W      = 5;
   localparam int HASH_SHIFT = 4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FLAGS,
      ST_LITS
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [LIT_IDX_W-1:0] addr;
      logic [WORD_W-1:0]    data;
   } lit_wr_type;

endpackage

FILE: hdl/lzpwc_predict_ram.sv
// Prediction table: single write port, single registered read port.
module lzpwc_predict_ram #(
   parameter int TABLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [TABLE_BITS-1:0]          wr_addr,
   input  logic [lzpwc_pkg::WORD_W-1:0]   wr_data,
   input  logic                           rd_en,
   input  logic [TABLE_BITS-1:0]          rd_addr,
   output logic [lzpwc_pkg::WORD_W-1:0]   rd_data
);
   import lzpwc_pkg::*;

   localparam int Depth = 1 << TABLE_BITS;

   logic [WORD_W-1:0] mem [Depth];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lzpwc_literal_buf.sv
// Literal buffer: holds the missed words of the current block in arrival order.
module lzpwc_literal_buf (
   input  logic                              clock,
   input  lzpwc_pkg::lit_wr_type             wr,
   input  logic                              rd_en,
   input  logic [lzpwc_pkg::LIT_IDX_W-1:0]   rd_addr,
   output logic [lzpwc_pkg::WORD_W-1:0]      rd_data
);
   import lzpwc_pkg::*;

   logic [WORD_W-1:0] mem [LIT_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lzp_word_compressor_core.sv
// Top level of the LZP word compressor: control, context hash and output register.
//
//   channel  | handshake             | payload
//   req_     | req_valid/req_ready   | req_in_word[15:0], req_end_of_input
//   rsp_     | rsp_valid/rsp_ready   | rsp_out_word[15:0], rsp_is_flags, rsp_run_last
//
// Each word takes a table read, then a compare and, on a miss, a write back.
// A block flush emits 1 + literal count words, one per cycle while rsp_ready is high.
// After reset the table is cleared one entry a cycle, all 2**TABLE_BITS entries,
// before the first word is taken. Output stalls hold the flush; the last
// flushed word waits in the output register while the next word is taken.
module lzp_word_compressor_core #(
   parameter int BLOCK_LEN  = 16,
   parameter int TABLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lzpwc_pkg::WORD_W-1:0]   req_in_word,
   input  logic                           req_end_of_input,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lzpwc_pkg::WORD_W-1:0]   rsp_out_word,
   output logic                           rsp_is_flags,
   output logic                           rsp_run_last
);
   import lzpwc_pkg::*;

   state_type             state_ff, state_in;
   logic [TABLE_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [TABLE_BITS-1:0] hash_ff, hash_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [WORD_W-1:0]     flags_ff, flags_in;
   logic [LIT_IDX_W-1:0]  k_ff, k_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic                  end_ff, end_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic                  rsp_flags_ff, rsp_flags_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  tbl_we;
   logic [TABLE_BITS-1:0] tbl_waddr;
   logic [WORD_W-1:0]     tbl_wdata;
   logic                  tbl_re;
   logic [WORD_W-1:0]     tbl_rdata;
   lit_wr_type            lit_wr;
   logic                  lit_re;
   logic [LIT_IDX_W-1:0]  lit_raddr;
   logic [WORD_W-1:0]     lit_rdata;
   logic                  out_free;
   logic [TABLE_BITS-1:0] hash_shifted;
   logic [CNT_W-1:0]      k_next;

   lzpwc_predict_ram #(
      .TABLE_BITS (TABLE_BITS)
   ) u_predict_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (hash_ff),
      .rd_data (tbl_rdata)
   );

   lzpwc_literal_buf u_literal_buf (
      .clock   (clock),
      .wr      (lit_wr),
      .rd_en   (lit_re),
      .rd_addr (lit_raddr),
      .rd_data (lit_rdata)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_word = rsp_word_ff;
   assign rsp_is_flags = rsp_flags_ff;
   assign rsp_run_last = rsp_last_ff;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign hash_shifted = hash_ff << HASH_SHIFT;
   assign k_next       = {1'b0, k_ff} + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      hash_in      = hash_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      flags_in     = flags_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      word_in      = word_ff;
      end_in       = end_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_last_in  = rsp_last_ff;
      tbl_we       = 1'b0;
      tbl_waddr    = hash_ff;
      tbl_wdata    = word_ff;
      tbl_re       = 1'b0;
      lit_wr       = '0;
      lit_re       = 1'b0;
      lit_raddr    = k_next[LIT_IDX_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            tbl_we      = 1'b1;
            tbl_waddr   = clr_addr_ff;
            tbl_wdata   = '0;
            clr_addr_in = clr_addr_ff + TABLE_BITS'(1);
            if (clr_addr_ff == {TABLE_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               word_in  = req_in_word;
               end_in   = req_end_of_input;
               tbl_re   = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (tbl_rdata == word_ff) begin
               flags_in = flags_ff | (WORD_W'(1) << pos_ff[LIT_IDX_W-1:0]);
            end else begin
               tbl_we      = 1'b1;
               lit_wr.en   = 1'b1;
               lit_wr.addr = count_ff[LIT_IDX_W-1:0];
               lit_wr.data = word_ff;
               count_in    = count_ff + CNT_W'(1);
            end
            hash_in = hash_shifted ^ word_ff[TABLE_BITS-1:0];
            pos_in  = pos_ff + CNT_W'(1);
            if (pos_in >= CNT_W'(BLOCK_LEN) || end_ff) begin
               state_in = ST_FLAGS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLAGS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = flags_ff;
               rsp_flags_in = 1'b1;
               rsp_last_in  = (count_ff == '0);
               lit_re       = 1'b1;
               lit_raddr    = '0;
               k_in         = '0;
               if (count_ff == '0) begin
                  flags_in = '0;
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_LITS;
               end
            end
         end
         ST_LITS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = lit_rdata;
               rsp_flags_in = 1'b0;
               rsp_last_in  = (k_next == count_ff);
               lit_re       = 1'b1;
               k_in         = k_next[LIT_IDX_W-1:0];
               if (k_next == count_ff) begin
                  flags_in = '0;
                  count_in = '0;
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         hash_ff      <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         flags_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         hash_ff      <= hash_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      end_ff       <= end_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule
